// ===== sv/ctd_pkg.sv =====
// ---------------------------------------------------------------------------
// ctd_pkg
// shared types, codes and constants of the chunked transfer dispatcher
// ---------------------------------------------------------------------------
package ctd_pkg;

  // fixed field widths of the ports, the order rule and the lfsr
  localparam int SIZE_W       = 48;
  localparam int FILE_INDEX_W = 8;
  localparam int RULE_W       = 2;
  localparam int LFSR_W       = 16;

  // parameter defaults
  localparam int MAX_FILES_DEF = 256;
  localparam int SIZE_BITS_DEF = 48;

  localparam logic [SIZE_W-1:0] CHUNK_RESET = SIZE_W'(1048576);
  localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic REG_ORDER_RULE   = 1'b0;
  localparam logic REG_CHUNK_LENGTH = 1'b1;

  // order rules
  localparam logic [RULE_W-1:0] RULE_STACK_FIRST = 2'd0;
  localparam logic [RULE_W-1:0] RULE_NEW_FIRST   = 2'd1;
  localparam logic [RULE_W-1:0] RULE_RANDOM      = 2'd2;
  localparam logic [RULE_W-1:0] RULE_RANDOM_ALT  = 2'd3;

  // where the next piece comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_STACK,
    SRC_NEW
  } src_t;

  typedef struct packed {
    logic step;         // a request is being accepted
    logic stack_avail;  // partly issued files remain
    logic new_avail;    // unissued files remain
  } pick_req_t;

endpackage

// ===== sv/ctd_order_pick.sv =====
// ---------------------------------------------------------------------------
// ctd_order_pick
// picks the piece source for each request and keeps the choice lfsr
// ---------------------------------------------------------------------------
module ctd_order_pick
  import ctd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [RULE_W-1:0] order_rule,
  input  pick_req_t         req,
  output src_t              src
);

  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic              random_rule;
  logic              new_first;

  // taps 16,14,13,11, shifted in at the top
  assign lfsr_next   = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
  assign random_rule = (order_rule == RULE_RANDOM) || (order_rule == RULE_RANDOM_ALT);

  always_comb begin
    if (random_rule) begin
      new_first = lfsr_next[0];
    end else begin
      new_first = (order_rule == RULE_NEW_FIRST);
    end
    if (new_first) begin
      src = req.new_avail ? SRC_NEW : (req.stack_avail ? SRC_STACK : SRC_NONE);
    end else begin
      src = req.stack_avail ? SRC_STACK : (req.new_avail ? SRC_NEW : SRC_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (req.step && random_rule) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

// ===== sv/chunked_transfer_dispatcher.sv =====
// ---------------------------------------------------------------------------
// chunked_transfer_dispatcher
// hands out file transfer work as chunk-sized pieces
// ---------------------------------------------------------------------------
// Command channel (cmd_valid / cmd_stall): operation 0 appends file_size to
// the size table, operation 1 asks for the next piece. Piece channel
// (piece_valid / piece_stall) returns granted, file_index and start_offset,
// one item per request and none per load.
// A load is written to the size table at its accept edge. A request's accept
// edge reads the size table and the top of the pending stack (both synchronous
// memories); the update state then updates the stack and counters and fills
// the output register. No command is accepted until that update is done.
// The output register lets the next command be accepted while a piece waits;
// if the receiver still stalls when the following request finishes, that
// request holds in its update state and cmd_stall stays high.
// Reset empties the table and stack counters, restores order_rule to 0,
// chunk_length to 1048576 and the choice lfsr seed. No clearing pass is run.
// Configuration writes (write_enable, write_index, write_data) take effect
// at once; the user must make them only while the block is idle, as the block does not enforce it.
// ---------------------------------------------------------------------------
module chunked_transfer_dispatcher
  import ctd_pkg::*;
#(
  parameter int MAX_FILES = MAX_FILES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    write_enable,
  input  logic                    write_index,
  input  logic [SIZE_W-1:0]       write_data,
  // commands
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  logic                    operation,
  input  logic [SIZE_W-1:0]       file_size,
  // pieces
  output logic                    piece_valid,
  input  logic                    piece_stall,
  output logic                    granted,
  output logic [FILE_INDEX_W-1:0] file_index,
  output logic [SIZE_W-1:0]       start_offset
);

  localparam int IDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W = $clog2(MAX_FILES + 1);

  typedef struct packed {
    logic [IDX_W-1:0]     file;
    logic [SIZE_BITS-1:0] offset;
    logic [SIZE_BITS-1:0] remain;   // bytes from offset to end of file
  } stack_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t               state;
  src_t                 src;
  src_t                 src_q;
  logic [RULE_W-1:0]    order_rule;
  logic [SIZE_W-1:0]    chunk_length;
  logic [SIZE_BITS-1:0] chunk_raw;
  logic [SIZE_BITS-1:0] chunk_eff;

  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     issue_cursor;
  logic [CNT_W-1:0]     pending_depth;
  logic [CNT_W-1:0]     depth_dec;
  logic [IDX_W-1:0]     top_idx;

  logic [SIZE_BITS-1:0] size_table [MAX_FILES];
  stack_entry_t         stack_mem  [MAX_FILES];
  logic [SIZE_BITS-1:0] size_rd;
  stack_entry_t         stk_rd;

  logic                 cmd_take;
  logic                 load_take;
  logic                 req_take;
  logic                 out_free;
  logic                 finish;
  logic                 stk_we;
  logic [IDX_W-1:0]     stk_waddr;
  stack_entry_t         stk_wdata;
  logic                 pop;
  logic                 push;
  pick_req_t            pick_req;

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign load_take = cmd_take && (operation == OP_LOAD);
  assign req_take  = cmd_take && (operation == OP_REQUEST);
  assign out_free  = !piece_valid || !piece_stall;
  assign finish    = (state == ST_RUN) && out_free;

  assign chunk_raw = SIZE_BITS'(chunk_length);
  assign chunk_eff = (chunk_raw == '0) ? SIZE_BITS'(1) : chunk_raw;
  assign depth_dec = pending_depth - CNT_W'(1);
  assign top_idx   = depth_dec[IDX_W-1:0];

  assign pick_req.step        = req_take;
  assign pick_req.stack_avail = (pending_depth != '0);
  assign pick_req.new_avail   = (issue_cursor < loaded_count);

  ctd_order_pick u_pick (
    .clk        (clk),
    .rst        (rst),
    .order_rule (order_rule),
    .req        (pick_req),
    .src        (src)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_rule   <= RULE_STACK_FIRST;
      chunk_length <= CHUNK_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_ORDER_RULE:   order_rule   <= write_data[RULE_W-1:0];
        REG_CHUNK_LENGTH: chunk_length <= write_data;
        default:          ;
      endcase
    end
  end

  // size table: written by loads, read at the issue cursor
  always_ff @(posedge clk) begin
    if (load_take && (loaded_count < CNT_W'(MAX_FILES))) begin
      size_table[loaded_count[IDX_W-1:0]] <= SIZE_BITS'(file_size);
    end
    if (req_take) begin
      size_rd <= size_table[issue_cursor[IDX_W-1:0]];
    end
  end

  // pending stack: read at the top, written back or pushed on completion
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (req_take) begin
      stk_rd <= stack_mem[top_idx];
    end
  end

  always_comb begin
    stk_we           = 1'b0;
    stk_waddr        = top_idx;
    stk_wdata        = stk_rd;
    pop              = 1'b0;
    push             = 1'b0;
    case (src_q)
      SRC_STACK: begin
        if (stk_rd.remain <= chunk_eff) begin
          pop = 1'b1;
        end else begin
          stk_we           = finish;
          stk_wdata.offset = stk_rd.offset + chunk_eff;
          stk_wdata.remain = stk_rd.remain - chunk_eff;
        end
      end
      SRC_NEW: begin
        if ((size_rd > chunk_eff) && (pending_depth < CNT_W'(MAX_FILES))) begin
          push             = 1'b1;
          stk_we           = finish;
          stk_waddr        = pending_depth[IDX_W-1:0];
          stk_wdata.file   = issue_cursor[IDX_W-1:0];
          stk_wdata.offset = chunk_eff;
          stk_wdata.remain = size_rd - chunk_eff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loaded_count  <= '0;
      issue_cursor  <= '0;
      pending_depth <= '0;
      piece_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (piece_valid && !piece_stall) begin
            piece_valid <= 1'b0;
          end
          if (load_take && (loaded_count < CNT_W'(MAX_FILES))) begin
            loaded_count <= loaded_count + CNT_W'(1);
          end
          if (req_take) begin
            src_q <= src;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          // a waiting piece taken at this edge is replaced at once
          if (out_free) begin
            piece_valid <= 1'b1;
            state       <= ST_IDLE;
            case (src_q)
              SRC_STACK: begin
                granted      <= 1'b1;
                file_index   <= FILE_INDEX_W'(stk_rd.file);
                start_offset <= SIZE_W'(stk_rd.offset);
                if (pop) begin
                  pending_depth <= depth_dec;
                end
              end
              SRC_NEW: begin
                granted      <= 1'b1;
                file_index   <= FILE_INDEX_W'(issue_cursor[IDX_W-1:0]);
                start_offset <= '0;
                issue_cursor <= issue_cursor + CNT_W'(1);
                if (push) begin
                  pending_depth <= pending_depth + CNT_W'(1);
                end
              end
              default: begin
                granted      <= 1'b0;
                file_index   <= '0;
                start_offset <= '0;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // each file is pushed at most once, and only after it has been issued
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    pending_depth <= issue_cursor)
    else $error("pending stack deeper than issued files");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cursor <= loaded_count)
    else $error("issue cursor passed the loaded files");

  a_empty_piece: assert property (@(posedge clk) disable iff (rst)
    piece_valid && !granted |-> (file_index == '0) && (start_offset == '0))
    else $error("refused piece carries a file or offset");

  a_request_runs: assert property (@(posedge clk) disable iff (rst)
    req_take |=> (state == ST_RUN) && !piece_valid || (state == ST_RUN) && cmd_stall)
    else $error("request did not enter its update cycle");

  a_stack_top_valid: assert property (@(posedge clk) disable iff (rst)
    finish && (src_q == SRC_STACK) |-> pending_depth != '0)
    else $error("stack piece taken from an empty stack");

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the chunked transfer dispatcher: a queue-fed
// driver sends loads and piece requests in random bursts, a checker
// predicts every piece and compares it with what comes out under random
// back-pressure, across several order rules and chunk lengths
// ---------------------------------------------------------------------------
module testbench;
  import ctd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic                    granted;
    logic [FILE_INDEX_W-1:0] file_index;
    logic [SIZE_W-1:0]       start_offset;
  } piece_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    write_enable = 1'b0;
  logic                    write_index  = REG_ORDER_RULE;
  logic [SIZE_W-1:0]       write_data   = '0;
  logic                    cmd_valid    = 1'b0;
  logic                    cmd_stall;
  logic                    operation    = OP_LOAD;
  logic [SIZE_W-1:0]       file_size    = '0;
  logic                    piece_valid;
  logic                    piece_stall  = 1'b0;
  logic                    granted;
  logic [FILE_INDEX_W-1:0] file_index;
  logic [SIZE_W-1:0]       start_offset;

  chunked_transfer_dispatcher uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .operation    (operation),
    .file_size    (file_size),
    .piece_valid  (piece_valid),
    .piece_stall  (piece_stall),
    .granted      (granted),
    .file_index   (file_index),
    .start_offset (start_offset)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the dispatcher state
  logic [SIZE_W-1:0]       size_tab  [MAX_FILES_DEF];
  logic [FILE_INDEX_W-1:0] part_file [MAX_FILES_DEF];
  logic [SIZE_W-1:0]       part_ofs  [MAX_FILES_DEF];
  int                      files_loaded = 0;
  int                      next_new     = 0;
  int                      part_depth   = 0;
  logic [LFSR_W-1:0]       choice_reg   = LFSR_SEED;
  logic [RULE_W-1:0]       rule_reg     = RULE_STACK_FIRST;
  logic [SIZE_W-1:0]       chunk_reg    = CHUNK_RESET;

  cmd_t   cmd_backlog [$];
  piece_t pieces_due  [$];
  int     items_sent = 0;
  int     loads_sent = 0;
  bit     run_failed = 1'b0;
  logic   cmd_taken  = 1'b0;
  int     cycles     = 0;

  function automatic logic [SIZE_W-1:0] chunk_of(input logic [SIZE_W-1:0] c);
    return (c == '0) ? SIZE_W'(1) : c;
  endfunction

  function automatic bit take_partial(output logic [FILE_INDEX_W-1:0] idx,
                                      output logic [SIZE_W-1:0] ofs);
    int                top;
    logic [SIZE_W-1:0] left;
    idx = '0;
    ofs = '0;
    if (part_depth == 0) return 1'b0;
    top = part_depth - 1;
    idx = part_file[top];
    ofs = part_ofs[top];
    left = (size_tab[idx] >= ofs) ? size_tab[idx] - ofs : '0;
    if (left <= chunk_of(chunk_reg)) part_depth = top;
    else part_ofs[top] = ofs + chunk_of(chunk_reg);
    return 1'b1;
  endfunction

  function automatic bit take_fresh(output logic [FILE_INDEX_W-1:0] idx,
                                    output logic [SIZE_W-1:0] ofs);
    idx = '0;
    ofs = '0;
    if (next_new >= files_loaded) return 1'b0;
    idx = FILE_INDEX_W'(next_new);
    // files over one chunk stay on the stack for their later pieces
    if (size_tab[next_new] > chunk_of(chunk_reg)) begin
      part_file[part_depth] = idx;
      part_ofs[part_depth]  = chunk_of(chunk_reg);
      part_depth++;
    end
    next_new++;
    return 1'b1;
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    logic [RULE_W-1:0]       rule;
    logic [FILE_INDEX_W-1:0] idx;
    logic [SIZE_W-1:0]       ofs;
    bit                      ok;
    piece_t                  p;
    if (c.op == OP_LOAD) begin
      if (files_loaded < MAX_FILES_DEF) begin
        size_tab[files_loaded] = c.size;
        files_loaded++;
      end
      return;
    end
    rule = rule_reg;
    if (rule == RULE_RANDOM || rule == RULE_RANDOM_ALT) begin
      choice_reg = {choice_reg[0] ^ choice_reg[2] ^ choice_reg[3] ^ choice_reg[5],
                    choice_reg[LFSR_W-1:1]};
      rule = choice_reg[0] ? RULE_NEW_FIRST : RULE_STACK_FIRST;
    end
    if (rule == RULE_STACK_FIRST) begin
      ok = take_partial(idx, ofs);
      if (!ok) ok = take_fresh(idx, ofs);
    end else begin
      ok = take_fresh(idx, ofs);
      if (!ok) ok = take_partial(idx, ofs);
    end
    p.granted      = ok;
    p.file_index   = ok ? idx : '0;
    p.start_offset = ok ? ofs : '0;
    pieces_due.insert(pieces_due.size(), p);
  endfunction

  function automatic logic [SIZE_W-1:0] rand_word();
    return SIZE_W'({$urandom, $urandom});
  endfunction

  // mostly a handful of chunks, sometimes anything the field allows
  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] chunk);
    logic [63:0] c;
    logic [63:0] s;
    c = 64'(chunk_of(chunk));
    s = c * 64'($urandom_range(0, 9)) + ({$urandom, $urandom} % c);
    if (s[63:SIZE_W] != '0 || (c > 64'(1) << 44 && $urandom_range(0, 9) == 0))
      s = 64'(rand_word());
    return s[SIZE_W-1:0];
  endfunction

  function automatic void queue_cmd(input logic op, input logic [SIZE_W-1:0] size);
    cmd_t c;
    c.op   = op;
    c.size = size;
    cmd_backlog.insert(cmd_backlog.size(), c);
    // loads into a full table are dropped by the block and not counted
    if (op == OP_REQUEST || loads_sent < MAX_FILES_DEF) items_sent++;
    if (op == OP_LOAD) loads_sent++;
  endfunction

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    if (idx == REG_ORDER_RULE) rule_reg = val[RULE_W-1:0];
    else chunk_reg = val;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || cmd_valid || pieces_due.size() != 0)
      @(posedge clk);
    // a trailing load may still be in flight
    repeat (4) @(posedge clk);
  endtask

  // command driver
  int   burst_left = 8;
  int   gap_left   = 0;
  cmd_t cur_cmd    = '0;

  always @(posedge clk) cmd_taken <= !rst && cmd_valid && cmd_stall === 1'b0;

  always @(negedge clk) begin
    logic nv;
    nv = cmd_valid;
    if (cmd_taken) begin
      apply_cmd(cur_cmd);
      nv = 1'b0;
    end
    if (!nv && !rst) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() != 0) begin
        cur_cmd = cmd_backlog.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    cmd_valid <= nv;
    operation <= cur_cmd.op;
    file_size <= cur_cmd.size;
  end

  // receiver back-pressure, switching pattern every so often
  int stall_mode = 0;
  int mode_left  = 100;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: piece_stall <= 1'b0;
      1: piece_stall <= ($urandom_range(0, 99) < 30);
      2: piece_stall <= ($urandom_range(0, 99) < 85);
      default: piece_stall <= (cycles % 7) < 4;
    endcase
  end

  // piece checker
  always @(posedge clk) begin
    piece_t want;
    if (!rst && piece_valid === 1'b1 && piece_stall === 1'b0) begin
      if (pieces_due.size() == 0) begin
        $error("piece with no request outstanding: granted %0d file %0d offset %0d",
               granted, file_index, start_offset);
        run_failed = 1'b1;
      end else begin
        want = pieces_due.pop_front();
        if (granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, granted);
          run_failed = 1'b1;
        end
        if (file_index !== want.file_index) begin
          $error("file_index: expected %0d, got %0d", want.file_index, file_index);
          run_failed = 1'b1;
        end
        if (start_offset !== want.start_offset) begin
          $error("start_offset: expected %0d, got %0d", want.start_offset, start_offset);
          run_failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] new_chunk;
    int                n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty block, then a file spread over four pieces
    // and an empty file
    queue_cmd(OP_REQUEST, rand_word());
    queue_cmd(OP_LOAD, SIZE_W'(3 * 1048576 + 5));
    queue_cmd(OP_LOAD, '0);
    repeat (6) queue_cmd(OP_REQUEST, '1);
    settle();

    // largest chunk, largest files, new files first
    write_reg(REG_ORDER_RULE, SIZE_W'(RULE_NEW_FIRST));
    write_reg(REG_CHUNK_LENGTH, '1);
    queue_cmd(OP_LOAD, '1);
    queue_cmd(OP_LOAD, {{(SIZE_W-1){1'b1}}, 1'b0});
    repeat (3) queue_cmd(OP_REQUEST, '0);
    settle();

    // zero chunk acts as one byte, under the alternate random rule
    write_reg(REG_ORDER_RULE, SIZE_W'(RULE_RANDOM_ALT));
    write_reg(REG_CHUNK_LENGTH, '0);
    queue_cmd(OP_LOAD, SIZE_W'(4));
    queue_cmd(OP_LOAD, SIZE_W'(2));
    repeat (7) queue_cmd(OP_REQUEST, rand_word());
    settle();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: new_chunk = SIZE_W'($urandom_range(0, 1));
        1: new_chunk = '1;
        default: new_chunk = rand_word() >> $urandom_range(0, SIZE_W - 1);
      endcase
      // finish off partly issued files before the chunk shrinks
      if (chunk_of(new_chunk) < chunk_of(chunk_reg)) begin
        while (part_depth != 0 || next_new < files_loaded) begin
          repeat (8) queue_cmd(OP_REQUEST, rand_word());
          settle();
        end
      end
      write_reg(REG_ORDER_RULE, SIZE_W'($urandom_range(0, 3)));
      write_reg(REG_CHUNK_LENGTH, new_chunk);
      n = $urandom_range(100, 240);
      repeat (n) begin
        if ($urandom_range(0, 99) < ((loads_sent < MAX_FILES_DEF) ? 20 : 3))
          queue_cmd(OP_LOAD, pick_size(new_chunk));
        else
          queue_cmd(OP_REQUEST, rand_word());
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (!run_failed && pieces_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
